// ----- sv/qpd_pkg.sv -----
// Shared types and constants for the quoted-printable decoder.
`timescale 1ns / 1ps

package qpd_pkg;

  localparam int unsigned QPD_FIFO_DEPTH = 4;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] ALPHA_OFS = 8'd10;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_EQ    = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  typedef struct packed {
    esc_t       esc;
    logic [7:0] held;
    logic       stopped;
  } dec_state_t;

endpackage

// ----- sv/qpd_step.sv -----
// Per-byte decode: next decoder state and up to two result entries.
`timescale 1ns / 1ps

module qpd_step (
  input  logic              qp_en,
  input  logic [7:0]        c,
  input  logic              last,
  input  qpd_pkg::dec_state_t st,
  output qpd_pkg::dec_state_t st_nxt,
  output logic [1:0]        n_res,
  output qpd_pkg::res_t     res0,
  output qpd_pkg::res_t     res1
);
  import qpd_pkg::*;

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || (b >= CH_A && b <= CH_Z) ||
           (b >= CH_LA && b <= CH_LZ);
  endfunction

  function automatic logic [7:0] digit_of(input logic [7:0] b);
    return (b >= CH_A) ? (b - CH_A + ALPHA_OFS) : (b - CH_ZERO);
  endfunction

  logic [7:0] hi_dig;
  logic [7:0] hex_val;
  logic       plain;      // run the plain-byte rule on c
  logic       emit_held;  // emit the held digit before anything else

  assign hi_dig  = digit_of(st.held);
  assign hex_val = {hi_dig[3:0], 4'h0} + digit_of(c);

  always_comb begin
    st_nxt    = st;
    plain     = 1'b0;
    emit_held = 1'b0;
    n_res     = 2'd0;
    res0      = '0;
    res1      = '0;

    if (!st.stopped && c != CH_CR) begin
      if (!qp_en) begin
        st_nxt.esc = ESC_IDLE;
        plain      = 1'b1;
      end else begin
        st_nxt.esc = ESC_IDLE;
        case (st.esc)
          ESC_EQ: begin
            if (c == CH_LF) begin
              // soft line break: drop both
            end else if (is_alnum(c)) begin
              st_nxt.held = c;
              st_nxt.esc  = ESC_DIGIT;
            end else begin
              plain = 1'b1;
            end
          end
          ESC_DIGIT: begin
            if (is_alnum(c)) begin
              res0  = '{data: hex_val, valid: 1'b1, last: 1'b0};
              n_res = 2'd1;
            end else begin
              emit_held = 1'b1;
              plain     = 1'b1;
            end
          end
          default: plain = 1'b1;
        endcase
      end
    end

    if (emit_held) begin
      res0  = '{data: st.held, valid: 1'b1, last: 1'b0};
      n_res = 2'd1;
    end

    if (plain) begin
      if (c == 8'd0) begin
        st_nxt.stopped = 1'b1;
      end else if (c == CH_EQ && qp_en) begin
        st_nxt.esc = ESC_EQ;
      end else if (n_res == 2'd0) begin
        res0  = '{data: c, valid: 1'b1, last: 1'b0};
        n_res = 2'd1;
      end else begin
        res1  = '{data: c, valid: 1'b1, last: 1'b0};
        n_res = 2'd2;
      end
    end

    if (last) begin
      // flush a pending digit, including one taken on this byte
      if (!st.stopped && qp_en && st_nxt.esc == ESC_DIGIT) begin
        if (n_res == 2'd0) begin
          res0  = '{data: st_nxt.held, valid: 1'b1, last: 1'b0};
          n_res = 2'd1;
        end else if (n_res == 2'd1) begin
          res1  = '{data: st_nxt.held, valid: 1'b1, last: 1'b0};
          n_res = 2'd2;
        end
      end
      if (n_res == 2'd0) begin
        res0  = '{data: 8'd0, valid: 1'b0, last: 1'b0};
        n_res = 2'd1;
      end
      if (n_res == 2'd1) res0.last = 1'b1;
      else               res1.last = 1'b1;
      st_nxt = '{esc: ESC_IDLE, held: 8'd0, stopped: 1'b0};
    end
  end

endmodule

// ----- sv/quoted_printable_decoder_unit.sv -----
// Top level: input register, per-byte decode, result queue.
// A byte accepted into the input register is decoded from there and its results
// are pushed into the result queue, whose head is presented as the output beat.
// Throughput: one input beat per cycle while results leave at one per cycle;
// a byte with two results needs two output beats, so a run of such bytes
// stalls the input whenever the result queue holds more than two entries.
// Reset (rst_n low, synchronous): qp_enable off, no escape pending,
// input register and result queue empty.
`timescale 1ns / 1ps

module quoted_printable_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,      // qp_enable
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] data_byte
  input  logic       in_tlast,      // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tuser,     // out_valid
  output logic       out_tlast      // out_last
);
  import qpd_pkg::*;

  localparam int unsigned FIFO_DEPTH = QPD_FIFO_DEPTH;
  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic             qp_en_r;
  logic             s1_v_r;
  logic [7:0]       s1_byte_r;
  logic             s1_last_r;
  dec_state_t       st_r, st_nxt;
  logic [1:0]       n_res;
  res_t             res0, res1;
  res_t             q_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             room, s1_adv, pop;
  logic [1:0]       push_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) qp_en_r <= 1'b0;
    else if (cfg_valid) qp_en_r <= cfg_data;
  end

  assign room      = cnt_r <= CNT_W'(FIFO_DEPTH - 2);
  assign s1_adv    = s1_v_r && room;
  assign in_tready = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  qpd_step u_step (
    .qp_en  (qp_en_r),
    .c      (s1_byte_r),
    .last   (s1_last_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .n_res  (n_res),
    .res0   (res0),
    .res1   (res1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{esc: ESC_IDLE, held: 8'd0, stopped: 1'b0};
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // result queue: push up to two entries, pop one
  assign pop    = out_tvalid && out_tready;
  assign push_n = s1_adv ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_r] <= res0;
    if (push_n == 2'd2) q_r[wr_r + PTR_W'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(push_n);
      if (pop) rd_r <= rd_r + PTR_W'(1);
      cnt_r <= cnt_r + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  assign out_tvalid = cnt_r != '0;
  assign out_tdata  = q_r[rd_r].data;
  assign out_tuser  = q_r[rd_r].valid;
  assign out_tlast  = q_r[rd_r].last;

endmodule

// ----- verif/qpd_checker.sv -----
// Scoreboard for the quoted-printable decoder: predicts result beats and checks them.
`timescale 1ns / 1ps

module qpd_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  input  logic       out_tuser,
  input  logic       out_tlast,
  output int         fail_count,
  output int         pending,
  output int         results_checked,
  output int         escapes_decoded
);
  import qpd_pkg::*;

  // Model copy of the decoder state and mode register
  logic       qp_on;
  esc_t       esc;
  logic [7:0] held;
  logic       halted;

  res_t       byte_results[$];
  res_t       expected_results[$];
  int         fails;
  int         checked;
  int         decoded;

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_A && c <= CH_Z) ||
           (c >= CH_LA && c <= CH_LZ);
  endfunction

  // Loose digit rule: anything at or above 'A' counts as a letter digit
  function automatic logic [7:0] digit_value(logic [7:0] c);
    return (c >= CH_A) ? c - CH_A + ALPHA_OFS : c - CH_ZERO;
  endfunction

  task automatic emit(logic [7:0] b, logic v);
    if (byte_results.size() < 2)
      byte_results.push_back('{data: b, valid: v, last: 1'b0});
  endtask

  task automatic take_plain(logic [7:0] c);
    if (c == 8'h00)
      halted = 1'b1;
    else if (c == CH_EQ && qp_on)
      esc = ESC_EQ;
    else
      emit(c, 1'b1);
  endtask

  task automatic decode_beat(logic [7:0] c, logic lst);
    logic [7:0] hi;
    res_t       tail;
    byte_results.delete();
    if (!halted && c != CH_CR) begin
      if (!qp_on) begin
        esc = ESC_IDLE;
        take_plain(c);
      end else if (esc == ESC_EQ) begin
        esc = ESC_IDLE;
        if (is_alnum(c)) begin
          held = c;
          esc  = ESC_DIGIT;
        end else if (c != CH_LF) begin
          take_plain(c);
        end
      end else if (esc == ESC_DIGIT) begin
        esc = ESC_IDLE;
        if (is_alnum(c)) begin
          hi = digit_value(held);
          emit({hi[3:0], 4'h0} + digit_value(c), 1'b1);
          decoded++;
        end else begin
          // broken escape: release the held digit, then treat this byte as text
          emit(held, 1'b1);
          take_plain(c);
        end
      end else begin
        take_plain(c);
      end
    end
    if (lst) begin
      if (!halted && qp_on && esc == ESC_DIGIT)
        emit(held, 1'b1);
      if (byte_results.size() == 0)
        emit(8'h00, 1'b0);
      tail = byte_results.pop_back();
      tail.last = 1'b1;
      byte_results.push_back(tail);
      esc    = ESC_IDLE;
      held   = '0;
      halted = 1'b0;
    end
    foreach (byte_results[i])
      expected_results.push_back(byte_results[i]);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      qp_on   = 1'b0;
      esc     = ESC_IDLE;
      held    = '0;
      halted  = 1'b0;
      fails   = 0;
      checked = 0;
      decoded = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        qp_on = cfg_data;
      // Check the outgoing beat before predicting from this edge's input beat
      if (out_tvalid && out_tready) begin
        got = '{data: out_tdata, valid: out_tuser, last: out_tlast};
        checked++;
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("[%0t] unexpected result: data=%02h valid=%b last=%b",
                     $realtime, got.data, got.valid, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fails++;
            if (fails <= 10)
              $display({"[%0t] result %0d: expected data=%02h valid=%b last=%b,",
                        " got data=%02h valid=%b last=%b"},
                       $realtime, checked, want.data, want.valid, want.last,
                       got.data, got.valid, got.last);
          end
        end
      end
      if (in_tvalid && in_tready)
        decode_beat(in_tdata, in_tlast);
    end
    fail_count      <= fails;
    pending         <= expected_results.size();
    results_checked <= checked;
    escapes_decoded <= decoded;
  end

endmodule

// ----- verif/tb_top.sv -----
// Top of the quoted-printable decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import qpd_pkg::*;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic       cfg_data   = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  int chk_fails;
  int chk_pending;
  int chk_results;
  int chk_escapes;

  int beats;
  int messages;
  int modes_written;
  int stall_left;
  bit pace;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quoted_printable_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  qpd_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .fail_count      (chk_fails),
    .pending         (chk_pending),
    .results_checked (chk_results),
    .escapes_decoded (chk_escapes)
  );

  // Result side backpressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pace && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // All tasks below start and end right after a rising edge
  task automatic write_mode(logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    modes_written++;
  endtask

  task automatic send_beat(logic [7:0] b, logic lst);
    if (pace && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    beats++;
  endtask

  task automatic send_message(logic [7:0] msg[$]);
    foreach (msg[i])
      send_beat(msg[i], i == msg.size() - 1);
    messages++;
  endtask

  // Let every expected beat arrive, then give the pipeline time to empty
  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 36) return CH_A + 8'(r - 10);
    return CH_LA + 8'(r - 36);
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 15);
    return (r < 10) ? CH_ZERO + 8'(r) : CH_A + 8'(r - 10);
  endfunction

  function automatic logic [7:0] pick_non_alnum();
    return $urandom_range(0, 1) ? 8'($urandom_range(32, 47)) : 8'($urandom_range(123, 255));
  endfunction

  // Mostly well-formed encoded text, with broken escapes and raw noise mixed in
  task automatic build_message(output logic [7:0] msg[$]);
    int pieces;
    int kind;
    msg = {};
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      kind = $urandom_range(0, 19);
      case (kind)
        0, 1, 2, 3, 4, 5: begin
          msg.push_back(8'($urandom_range(32, 126)));
        end
        6, 7, 8: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_hex());
          msg.push_back(pick_hex());
        end
        9: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_alnum());
          msg.push_back(pick_alnum());
        end
        10: begin
          msg.push_back(CH_EQ);
          if ($urandom_range(0, 1)) msg.push_back(CH_CR);
          msg.push_back(CH_LF);
        end
        11: begin
          msg.push_back(CH_CR);
          msg.push_back(CH_LF);
        end
        12: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_alnum());
          msg.push_back(pick_non_alnum());
        end
        13: begin
          msg.push_back(CH_EQ);
          if ($urandom_range(0, 1)) msg.push_back(8'($urandom_range(0, 255)));
        end
        18: begin
          msg.push_back(CH_EQ);
          msg.push_back(pick_alnum());
        end
        19: begin
          msg.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
        end
        default: begin
          msg.push_back(8'($urandom_range(1, 255)));
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] msg[$];
    int         phase;
    int         phase_start;
    int         total_fails;

    beats = 0;
    messages = 0;
    modes_written = 0;
    pace = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: escapes, soft break, broken escapes, extremes, CR, flush, stop
    write_mode(1'b1);
    send_message('{CH_EQ, "4", "1", CH_EQ, CH_LF, CH_EQ, "!", CH_EQ, "4", "!",
                   CH_EQ, "z", "Z", CH_CR, 8'hFF});
    send_message('{CH_EQ, "7"});
    send_message('{CH_EQ});
    send_message('{"A", 8'h00, "B"});
    drain();
    write_mode(1'b0);
    send_message('{CH_EQ, CH_CR, 8'h80, 8'h00});
    drain();

    // Random phases, mostly with decoding on; the tail runs without idling
    phase = 0;
    while (beats < 1100) begin
      pace = (phase % 3 != 2) && (beats < 930);
      write_mode((phase % 4 == 3) ? 1'b0 : 1'b1);
      phase_start = beats;
      while (beats - phase_start < 120 && beats < 1100) begin
        build_message(msg);
        send_message(msg);
      end
      drain();
      phase++;
    end

    total_fails = chk_fails;
    if (chk_pending != 0) begin
      $display("%0d expected results never arrived", chk_pending);
      total_fails += chk_pending;
    end
    $display("Sent %0d bytes in %0d messages across %0d mode writes.",
             beats, messages, modes_written);
    $display("Checked %0d result beats, %0d of them decoded escapes; %0d mismatches.",
             chk_results, chk_escapes, total_fails);
    if (total_fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
